// File: rtl/srtf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam int ARR_W  = 16;
    localparam int BUR_W  = 8;
    localparam int TIME_W = 17;
    localparam int BEST_W = 9;
    localparam int JOB_W  = 4;

    localparam logic [BEST_W-1:0] NONE_LEFT  = '1;
    localparam logic [TIME_W-1:0] NO_ARRIVAL = '1;

    // scan token that walks the cell chain once per time unit
    typedef struct packed {
        logic              vld;
        logic [BEST_W-1:0] best;
        logic              choice;
        logic [TIME_W-1:0] next_arr;
    } t_token;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              load;
        logic              dec;
        logic [TIME_W-1:0] now;
        logic [ARR_W-1:0]  arrival;
        logic [BUR_W-1:0]  burst;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/srtf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface srtf_in_if import srtf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ARR_W-1:0] arrive_tick;
    logic [BUR_W-1:0] burst_len;
    logic             last;

    modport source (output valid, arrive_tick, burst_len, last, input ready);
    modport sink   (input valid, arrive_tick, burst_len, last, output ready);
endinterface

interface srtf_out_if import srtf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [JOB_W-1:0]  job_index;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              last_result;

    modport source (output valid, job_index, waiting_time, turnaround_time, last_result,
                    input ready);
    modport sink   (input valid, job_index, waiting_time, turnaround_time, last_result,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/srtf_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module srtf_cell import srtf_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  wire  [IW-1:0]      i_sel,
    input  wire  [CW-1:0]      i_count,
    input  t_token             i_tok,
    input  wire  [IW-1:0]      i_tok_idx,
    output t_token             o_tok,
    output logic [IW-1:0]      o_tok_idx,
    output logic [TIME_W-1:0]  o_wait,
    output logic [BUR_W-1:0]   o_burst
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [ARR_W-1:0]  r_arr;
    logic [BUR_W-1:0]  r_burst;
    logic [BUR_W-1:0]  r_rem;
    logic [TIME_W-1:0] r_wait;
    t_token            r_tok;
    logic [IW-1:0]     r_tok_idx;

    t_token            n_tok;
    logic [IW-1:0]     n_tok_idx;
    logic              active;
    logic              pending;
    logic [TIME_W:0]   finish;
    logic [TIME_W:0]   used;

    assign active  = (MY_POS < i_count);
    assign pending = active && (r_rem != '0);
    assign finish  = {1'b0, i_cmd.now} + 1'b1;
    assign used    = (TIME_W+1)'(r_burst) + (TIME_W+1)'(r_arr);

    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (pending && ({1'b0, r_arr} <= i_cmd.now) && ({1'b0, r_rem} < i_tok.best)) begin
            n_tok.best   = {1'b0, r_rem};
            n_tok.choice = 1'b1;
            n_tok_idx    = MY_IDX;
        end
        if (pending && ({1'b0, r_arr} < i_tok.next_arr)) begin
            n_tok.next_arr = {1'b0, r_arr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.best     <= n_tok.best;
        r_tok.choice   <= n_tok.choice;
        r_tok.next_arr <= n_tok.next_arr;
        r_tok_idx      <= n_tok_idx;

        if (i_cmd.load && i_sel == MY_IDX) begin
            r_arr   <= i_cmd.arrival;
            r_burst <= i_cmd.burst;
            r_rem   <= i_cmd.burst;
            r_wait  <= '0;
        end else if (i_cmd.dec && i_sel == MY_IDX) begin
            r_rem <= r_rem - 1'b1;
            if (r_rem == BUR_W'(1)) begin
                r_wait <= (finish > used) ? TIME_W'(finish - used) : '0;
            end
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;
    assign o_wait    = r_wait;
    assign o_burst   = r_burst;

endmodule

`default_nettype wire

// File: rtl/srtf_schedule_waiting_times.sv
// Preemptive shortest-remaining-time-first scheduler.
// Input channel i_job: one job per transaction (arrive_tick, burst_len, last).
// Jobs are held in a chain of MAX_PROCS cells; jobs beyond capacity are dropped.
// The transaction with last set starts the schedule over the jobs held.
// Output channel o_res: one transaction per held job in load order, giving
// waiting and turnaround time; last_result marks the final one.
// Each simulated time unit is one scan token walking the whole cell chain.
// An idle stretch with nothing arrived costs one time unit. Results then
// leave at one result per cycle while the receiver takes them.
// i_job.ready is high only while no set is being scheduled or emitted; one
// set is worked on at a time. Results sit in an output register: a stalled
// receiver holds the emitter, and the block takes the next set's jobs once the
// final result of a set has been registered.
// Reset (i_rst_n low, synchronous) empties the job set and the output register.
`timescale 1ns / 1ps
`default_nettype none

module srtf_schedule_waiting_times import srtf_pkg::*; #(
    parameter int MAX_PROCS = MAX_PROCS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    srtf_in_if.sink     i_job,
    srtf_out_if.source  o_res
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_PROCS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_zero;
    logic [CW-1:0]      r_done;
    logic [CW-1:0]      r_emit;
    logic [TIME_W-1:0]  r_time;
    logic [BEST_W-1:0]  r_best;
    logic [IW-1:0]      r_cur;
    logic               r_choice;

    logic               r_out_valid;
    logic [JOB_W-1:0]   r_out_idx;
    logic [TIME_W-1:0]  r_out_wait;
    logic [TIME_W-1:0]  r_out_tat;
    logic               r_out_last;

    t_token             w_tok     [MAX_PROCS+1];
    logic [IW-1:0]      w_tok_idx [MAX_PROCS+1];
    logic [TIME_W-1:0]  w_wait    [MAX_PROCS];
    logic [BUR_W-1:0]   w_burst   [MAX_PROCS];

    t_cmd               cmd;
    logic [IW-1:0]      sel;
    logic               in_take;
    logic               store;
    t_token             tail;
    logic [IW-1:0]      tail_idx;
    logic               out_free;
    logic [TIME_W-1:0]  rd_wait;
    logic [BUR_W-1:0]   rd_burst;

    assign in_take  = (r_state == S_IDLE) && i_job.valid;
    assign store    = in_take && (r_count < CAP);
    assign tail     = w_tok[MAX_PROCS];
    assign tail_idx = w_tok_idx[MAX_PROCS];
    assign out_free = !r_out_valid || o_res.ready;
    assign rd_wait  = w_wait[r_emit[IW-1:0]];
    assign rd_burst = w_burst[r_emit[IW-1:0]];

    always_comb begin
        cmd.load    = store;
        cmd.dec     = (r_state == S_WAIT) && tail.vld && tail.choice;
        cmd.now     = r_time;
        cmd.arrival = i_job.arrive_tick;
        cmd.burst   = i_job.burst_len;
        sel         = store ? r_count[IW-1:0] : tail_idx;

        w_tok[0].vld      = (r_state == S_ISSUE) && (r_done != r_count);
        w_tok[0].best     = r_best;
        w_tok[0].choice   = r_choice;
        w_tok[0].next_arr = NO_ARRIVAL;
        w_tok_idx[0]      = r_cur;
    end

    for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
        srtf_cell #(
            .IDX (k),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_sel     (sel),
            .i_count   (r_count),
            .i_tok     (w_tok[k]),
            .i_tok_idx (w_tok_idx[k]),
            .o_tok     (w_tok[k+1]),
            .o_tok_idx (w_tok_idx[k+1]),
            .o_wait    (w_wait[k]),
            .o_burst   (w_burst[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_zero      <= '0;
            r_done      <= '0;
            r_emit      <= '0;
            r_time      <= '0;
            r_best      <= NONE_LEFT;
            r_cur       <= '0;
            r_choice    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (store) begin
                            r_count <= r_count + 1'b1;
                            if (i_job.burst_len == '0) begin
                                r_zero <= r_zero + 1'b1;
                            end
                        end
                        if (i_job.last) begin
                            r_time   <= '0;
                            r_done   <= r_zero + CW'(store && i_job.burst_len == '0);
                            r_best   <= NONE_LEFT;
                            r_cur    <= '0;
                            r_choice <= 1'b0;
                            r_state  <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    if (r_done == r_count) begin
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (tail.vld) begin
                        if (tail.choice) begin
                            if (tail.best == BEST_W'(1)) begin
                                // job finishes at the end of this time unit
                                r_best   <= NONE_LEFT;
                                r_choice <= 1'b0;
                                r_done   <= r_done + 1'b1;
                            end else begin
                                r_best   <= tail.best - 1'b1;
                                r_choice <= 1'b1;
                            end
                            r_cur  <= tail_idx;
                            r_time <= r_time + 1'b1;
                        end else begin
                            // nothing ready: skip ahead to the earliest pending arrival
                            r_time <= (tail.next_arr > r_time) ? tail.next_arr
                                                               : r_time + 1'b1;
                        end
                        r_state <= S_ISSUE;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_idx   <= JOB_W'(r_emit);
                        r_out_wait  <= rd_wait;
                        r_out_tat   <= (rd_burst == '0) ? '0
                                                        : TIME_W'(rd_burst) + rd_wait;
                        r_out_last  <= (r_emit == r_count - 1'b1);
                        r_emit      <= r_emit + 1'b1;
                        if (r_emit == r_count - 1'b1) begin
                            r_count <= '0;
                            r_zero  <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_job.ready           = (r_state == S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.job_index       = r_out_idx;
    assign o_res.waiting_time    = r_out_wait;
    assign o_res.turnaround_time = r_out_tat;
    assign o_res.last_result     = r_out_last;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import srtf_pkg::*;

    localparam int LIMIT      = 10_000_000;
    localparam int MAX_JOBS   = MAX_PROCS_DEF;
    localparam int SETTLE     = 60;
    localparam int RAND_ITEMS = 110;

    typedef struct packed {
        logic [JOB_W-1:0]  job_index;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic              last_result;
    } t_job_times;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srtf_in_if  job_if ();
    srtf_out_if res_if ();

    srtf_schedule_waiting_times #(.MAX_PROCS(MAX_JOBS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // jobs of the set being loaded, as the block should hold them
    logic [ARR_W-1:0] held_arrival [MAX_JOBS];
    logic [BUR_W-1:0] held_burst   [MAX_JOBS];
    int               held_count;

    t_job_times job_times_q [$];

    int  errors;
    int  sets_scheduled;
    int  jobs_dropped;
    int  results_seen;
    int  cycles;
    bit  tx_calm;
    bit  rx_calm;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Preemptive SRTF over the held set; queues one result per job in load order.
    function automatic void schedule_job_set();
        int unsigned rem [MAX_JOBS];
        int unsigned wait_t [MAX_JOBS];
        int unsigned now;
        int unsigned best;
        int unsigned soonest;
        int unsigned used;
        int          left;
        int          run;
        int          j;
        bit          chosen;
        t_job_times  r;
        now    = 0;
        best   = 32'(NONE_LEFT);
        chosen = 1'b0;
        run    = 0;
        left   = 0;
        for (j = 0; j < held_count; j++) begin
            rem[j]    = 32'(held_burst[j]);
            wait_t[j] = 0;
            if (held_burst[j] != 0)
                left++;
        end
        while (left > 0) begin
            for (j = 0; j < held_count; j++) begin
                if (held_arrival[j] <= now && rem[j] > 0 && rem[j] < best) begin
                    best   = rem[j];
                    run    = j;
                    chosen = 1'b1;
                end
            end
            if (!chosen) begin
                soonest = 32'hFFFF_FFFF;
                for (j = 0; j < held_count; j++)
                    if (rem[j] > 0 && held_arrival[j] < soonest)
                        soonest = 32'(held_arrival[j]);
                now = (soonest > now) ? soonest : now + 1;
                continue;
            end
            rem[run]--;
            best = rem[run];
            if (best == 0) begin
                used        = 32'(held_burst[run]) + 32'(held_arrival[run]);
                wait_t[run] = (now + 1 > used) ? now + 1 - used : 0;
                best        = 32'(NONE_LEFT);
                chosen      = 1'b0;
                left--;
            end
            now++;
        end
        for (j = 0; j < held_count; j++) begin
            r.job_index       = j[JOB_W-1:0];
            r.waiting_time    = (held_burst[j] == 0) ? '0 : wait_t[j][TIME_W-1:0];
            r.turnaround_time = (held_burst[j] == 0) ? '0
                                : TIME_W'(held_burst[j] + wait_t[j]);
            r.last_result     = (j == held_count - 1);
            job_times_q.push_back(r);
        end
    endfunction

    task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BUR_W-1:0] bur,
                            input logic lst);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            job_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        job_if.valid       <= 1'b1;
        job_if.arrive_tick <= arr;
        job_if.burst_len   <= bur;
        job_if.last        <= lst;
        do @(posedge i_clk); while (!job_if.ready);
        if (held_count < MAX_JOBS) begin
            held_arrival[held_count] = arr;
            held_burst[held_count]   = bur;
            held_count++;
        end else begin
            jobs_dropped++;
        end
        if (lst) begin
            schedule_job_set();
            held_count = 0;
            sets_scheduled++;
        end
    endtask

    task automatic take_results();
        int         stall;
        t_job_times exp_r;
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            results_seen++;
            if (job_times_q.size() == 0) begin
                $error("result transaction with nothing expected: job_index %0d",
                       res_if.job_index);
                errors++;
            end else begin
                exp_r = job_times_q.pop_front();
                if (res_if.job_index !== exp_r.job_index) begin
                    $error("job_index: expected %0d, actual %0d",
                           exp_r.job_index, res_if.job_index);
                    errors++;
                end
                if (res_if.waiting_time !== exp_r.waiting_time) begin
                    $error("waiting_time: expected %0d, actual %0d",
                           exp_r.waiting_time, res_if.waiting_time);
                    errors++;
                end
                if (res_if.turnaround_time !== exp_r.turnaround_time) begin
                    $error("turnaround_time: expected %0d, actual %0d",
                           exp_r.turnaround_time, res_if.turnaround_time);
                    errors++;
                end
                if (res_if.last_result !== exp_r.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           exp_r.last_result, res_if.last_result);
                    errors++;
                end
            end
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
        end
    endtask

    // one job with the largest arrival and burst
    task automatic test_single_job();
        send_job(16'hFFFF, 8'd255, 1'b1);
    endtask

    // shorter arrivals preempt the running job
    task automatic test_preemption();
        send_job(16'd0, 8'd8, 1'b0);
        send_job(16'd1, 8'd4, 1'b0);
        send_job(16'd2, 8'd9, 1'b0);
        send_job(16'd3, 8'd5, 1'b1);
    endtask

    // equal remaining time does not preempt; idle gap; tie goes to lower index
    task automatic test_ties_and_idle();
        send_job(16'd0, 8'd4, 1'b0);
        send_job(16'd1, 8'd3, 1'b0);
        send_job(16'd40, 8'd2, 1'b0);
        send_job(16'd40, 8'd2, 1'b1);
    endtask

    // full set of long jobs, then two past capacity, the second one closing the set
    task automatic test_capacity();
        int k;
        for (k = 0; k < MAX_JOBS; k++)
            send_job((k % 2) ? 16'd0 : ARR_W'(k * 3), 8'd255, 1'b0);
        send_job(16'd5, 8'd1, 1'b0);
        send_job(16'd0, 8'd1, 1'b1);
    endtask

    task automatic test_random_sets();
        int               sent;
        int               size;
        int               spread;
        int               k;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
                1, 2:    size = $urandom_range(9, MAX_JOBS);
                default: size = $urandom_range(1, 8);
            endcase
            spread  = $urandom_range(0, 3);
            tx_calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < size; k++) begin
                case (spread)
                    0:       arr = ARR_W'($urandom_range(0, 7));
                    1:       arr = ARR_W'($urandom_range(0, 60));
                    2:       arr = ARR_W'($urandom_range(0, 65535));
                    default: arr = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                   : ARR_W'(32'h0000_FFFF - $urandom_range(0, 40));
                endcase
                case ($urandom_range(0, 15))
                    0:       bur = BUR_W'($urandom_range(128, 255));
                    1:       bur = 8'd255;
                    2:       bur = 8'd1;
                    default: bur = BUR_W'($urandom_range(1, 12));
                endcase
                send_job(arr, bur, k == size - 1);
            end
            sent += size;
        end
    endtask

    initial begin
        errors             = 0;
        sets_scheduled     = 0;
        jobs_dropped       = 0;
        results_seen       = 0;
        cycles             = 0;
        held_count         = 0;
        tx_calm            = 1'b0;
        rx_calm            = 1'b0;
        i_rst_n            <= 1'b0;
        job_if.valid       <= 1'b0;
        job_if.arrive_tick <= '0;
        job_if.burst_len   <= '0;
        job_if.last        <= 1'b0;
        res_if.ready       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            take_results();
        join_none

        test_single_job();
        test_preemption();
        test_ties_and_idle();
        test_capacity();
        test_random_sets();

        job_if.valid <= 1'b0;
        while (job_times_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("tb: %0d job sets scheduled, %0d jobs dropped past capacity",
                 sets_scheduled, jobs_dropped);
        $display("tb: %0d result transactions checked, %0d mismatches",
                 results_seen, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/srtf_pkg.sv
rtl/srtf_if.sv
rtl/srtf_cell.sv
rtl/srtf_schedule_waiting_times.sv
tb/tb.sv
